[design/bsr_pkg.sv]
// Shared types and constants for the BMP stream to RGB565 converter.
`default_nettype none
package bsr_pkg;

  localparam int unsigned MaxImageDim = 4096;
  localparam int unsigned DimW        = $clog2(MaxImageDim + 1);
  localparam int unsigned HeaderLast  = 33;
  localparam int unsigned FifoDepth   = 2;

  localparam logic [7:0] SigB = 8'h42;
  localparam logic [7:0] SigM = 8'h4D;
  localparam logic [15:0] Bpp24 = 16'd24;

  typedef enum logic [1:0] {
    ST_PIXEL   = 2'd0,
    ST_BAD_SIG = 2'd1,
    ST_UNSUP   = 2'd2
  } status_e;

  // One request from the parser to the output side.
  typedef struct packed {
    status_e          status;
    logic [DimW-1:0]  col;
    logic [DimW-1:0]  yoff;
    logic [15:0]      color;
    logic             last;
  } ev_t;

endpackage
`default_nettype wire

[design/bsr_front.sv]
// Byte parser: header fields, skip, pixel assembly, row padding.
`default_nettype none
module bsr_front (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            acc_i,
  input  wire [7:0]      data_byte_i,
  input  wire            start_of_file_i,
  output logic           ev_valid_o,
  output bsr_pkg::ev_t   ev_o
);
  import bsr_pkg::*;

  typedef enum logic [4:0] {
    PH_IDLE = 5'b00001,
    PH_HDR  = 5'b00010,
    PH_SKIP = 5'b00100,
    PH_PIX  = 5'b01000,
    PH_PAD  = 5'b10000
  } phase_e;

  phase_e          ph_q, ph_d, ph_c;
  logic [31:0]     pos_q, pos_d, pos_c;
  logic [31:0]     off_q, off_d, off_c;
  logic [31:0]     wid_q, wid_d, wid_c;
  logic [31:0]     hgt_q, hgt_d, hgt_c;
  logic [15:0]     bpp_q, bpp_d, bpp_c;
  logic            cmp_q, cmp_d, cmp_c;
  logic [DimW-1:0] col_q, col_d;
  logic [DimW-1:0] row_q, row_d;
  logic [1:0]      tri_q, tri_d;
  logic [1:0]      pad_q, pad_d;
  logic [7:0]      blu_q, blu_d, grn_q, grn_d;
  logic            w_noz, h_noz, bad_fmt, row_end, last;

  // Effective state after an optional restart
  always_comb begin
    ph_c  = start_of_file_i ? PH_HDR : ph_q;
    pos_c = start_of_file_i ? '0 : pos_q;
    off_c = start_of_file_i ? '0 : off_q;
    wid_c = start_of_file_i ? '0 : wid_q;
    hgt_c = start_of_file_i ? '0 : hgt_q;
    bpp_c = start_of_file_i ? '0 : bpp_q;
    cmp_c = start_of_file_i ? 1'b0 : cmp_q;
  end

  // Header field assembly, little-endian
  always_comb begin
    off_d = off_c; wid_d = wid_c; hgt_d = hgt_c; bpp_d = bpp_c; cmp_d = cmp_c;
    if (ph_c == PH_HDR) begin
      case (pos_c[5:0]) inside
        6'd10: off_d[7:0]   = data_byte_i;
        6'd11: off_d[15:8]  = data_byte_i;
        6'd12: off_d[23:16] = data_byte_i;
        6'd13: off_d[31:24] = data_byte_i;
        6'd18: wid_d[7:0]   = data_byte_i;
        6'd19: wid_d[15:8]  = data_byte_i;
        6'd20: wid_d[23:16] = data_byte_i;
        6'd21: wid_d[31:24] = data_byte_i;
        6'd22: hgt_d[7:0]   = data_byte_i;
        6'd23: hgt_d[15:8]  = data_byte_i;
        6'd24: hgt_d[23:16] = data_byte_i;
        6'd25: hgt_d[31:24] = data_byte_i;
        6'd28: bpp_d[7:0]   = data_byte_i;
        6'd29: bpp_d[15:8]  = data_byte_i;
        [6'd30:6'd33]: cmp_d = cmp_c | (data_byte_i != 8'd0);
        default: ;
      endcase
    end
  end

  assign w_noz = (wid_d == '0) || wid_d[31];
  assign h_noz = (hgt_d == '0) || hgt_d[31];
  assign bad_fmt = (bpp_d != Bpp24) || cmp_d || (off_d < 32'(HeaderLast + 1)) ||
                   (!w_noz && wid_d > 32'(MaxImageDim)) ||
                   (!h_noz && hgt_d > 32'(MaxImageDim));
  assign row_end = (col_q + 1'b1) == wid_q[DimW-1:0];
  assign last    = row_end && ((row_q + 1'b1) == hgt_q[DimW-1:0]);

  // Phase sequencing and event generation
  always_comb begin
    ph_d = ph_c; pos_d = pos_c;
    col_d = col_q; row_d = row_q; tri_d = tri_q; pad_d = pad_q;
    blu_d = blu_q; grn_d = grn_q;
    ev_valid_o = 1'b0;
    ev_o = '{status: ST_PIXEL, col: col_q,
             yoff: hgt_q[DimW-1:0] - 1'b1 - row_q,
             color: {data_byte_i[7:3], grn_q[7:2], blu_q[7:3]}, last: last};
    unique case (ph_c)
      PH_HDR: begin
        col_d = '0; row_d = '0; tri_d = '0; pad_d = '0;
        blu_d = '0; grn_d = '0;
        pos_d = pos_c + 32'd1;
        if ((pos_c == 32'd0 && data_byte_i != SigB) ||
            (pos_c == 32'd1 && data_byte_i != SigM)) begin
          ph_d = PH_IDLE;
          ev_valid_o = 1'b1;
          ev_o = '{status: ST_BAD_SIG, col: '0, yoff: '0, color: '0, last: 1'b0};
        end else if (pos_c == 32'(HeaderLast)) begin
          if (bad_fmt) begin
            ph_d = PH_IDLE;
            ev_valid_o = 1'b1;
            ev_o = '{status: ST_UNSUP, col: '0, yoff: '0, color: '0, last: 1'b0};
          end else if (w_noz || h_noz) begin
            ph_d = PH_IDLE;
          end else if (off_d == pos_d) begin
            ph_d = PH_PIX;
          end else begin
            ph_d = PH_SKIP;
          end
        end
      end
      PH_SKIP: begin
        pos_d = pos_c + 32'd1;
        if (pos_d == off_c) ph_d = PH_PIX;
      end
      PH_PIX: begin
        case (tri_q)
          2'd0: begin blu_d = data_byte_i; tri_d = 2'd1; end
          2'd1: begin grn_d = data_byte_i; tri_d = 2'd2; end
          default: begin
            tri_d = 2'd0;
            ev_valid_o = 1'b1;
            if (last) begin
              ph_d = PH_IDLE;
            end else if (row_end) begin
              col_d = '0;
              row_d = row_q + 1'b1;
              pad_d = wid_q[1:0];
              if (wid_q[1:0] != 2'd0) ph_d = PH_PAD;
            end else begin
              col_d = col_q + 1'b1;
            end
          end
        endcase
      end
      PH_PAD: begin
        pad_d = pad_q - 2'd1;
        if (pad_d == 2'd0) ph_d = PH_PIX;
      end
      default: ;
    endcase
    if (!acc_i) ev_valid_o = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PH_IDLE; pos_q <= '0; off_q <= '0; wid_q <= '0; hgt_q <= '0;
      bpp_q <= '0; cmp_q <= 1'b0; col_q <= '0; row_q <= '0; tri_q <= '0;
      pad_q <= '0; blu_q <= '0; grn_q <= '0;
    end else if (acc_i) begin
      ph_q <= ph_d; pos_q <= pos_d; off_q <= off_d; wid_q <= wid_d; hgt_q <= hgt_d;
      bpp_q <= bpp_d; cmp_q <= cmp_d; col_q <= col_d; row_q <= row_d; tri_q <= tri_d;
      pad_q <= pad_d; blu_q <= blu_d; grn_q <= grn_d;
    end
  end

`ifndef SYNTHESIS
  a_tri_range: assert property (@(posedge clk_i) disable iff (!rst_ni) tri_q != 2'd3)
    else $error("triple counter out of range");
  a_pad_only_in_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ph_q == PH_PAD |-> pad_q != 2'd0)
    else $error("pad phase with no pad bytes left");
  a_event_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_valid_o |-> acc_i)
    else $error("request without an accepted byte");
`endif
endmodule
`default_nettype wire

[design/bsr_fifo.sv]
// Two-entry request queue between parser and output stage.
`default_nettype none
module bsr_fifo (
  input  wire           clk_i,
  input  wire           rst_ni,
  input  wire           wr_i,
  input  bsr_pkg::ev_t  wdata_i,
  output logic          full_o,
  input  wire           rd_i,
  output bsr_pkg::ev_t  rdata_o,
  output logic          nempty_o
);
  import bsr_pkg::*;

  ev_t        mem_q [FifoDepth];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o   = cnt_q == 2'(FifoDepth);
  assign nempty_o = cnt_q != 2'd0;
  assign rdata_o  = mem_q[rp_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (wr_i) mem_q[wp_q] <= wdata_i;
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (wr_i) wp_q <= ~wp_q;
      if (rd_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, wr_i} - {1'b0, rd_i};
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_i |-> !full_o) else $error("queue write while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_i |-> nempty_o) else $error("queue read while empty");
  a_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'(FifoDepth)) else $error("queue level out of range");
`endif
endmodule
`default_nettype wire

[design/bsr_back.sv]
// Output stage: origin registers, screen position, result register.
`default_nettype none
module bsr_back (
  input  wire           clk_i,
  input  wire           rst_ni,
  input  wire           psel,
  input  wire           penable,
  input  wire           pwrite,
  input  wire  [2:0]    paddr,
  input  wire  [31:0]   pwdata,
  output logic [31:0]   prdata,
  input  wire           ev_nempty_i,
  input  bsr_pkg::ev_t  ev_i,
  output logic          ev_rd_o,
  output logic          empty,
  input  wire           pop,
  output logic [1:0]    status_o,
  output logic [15:0]   pixel_x_o,
  output logic [15:0]   pixel_y_o,
  output logic [15:0]   color_o,
  output logic          last_pixel_o
);
  import bsr_pkg::*;

  logic [15:0] ox_q, oy_q;
  logic        vld_q;
  logic [1:0]  st_q;
  logic [15:0] px_q, py_q, col_q;
  logic        last_q;
  logic        is_pix;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ox_q <= '0; oy_q <= '0;
    end else if (psel && penable && pwrite) begin
      if (paddr[2]) oy_q <= pwdata[15:0];
      else          ox_q <= pwdata[15:0];
    end
  end
  assign prdata = paddr[2] ? {16'd0, oy_q} : {16'd0, ox_q};

  // Result register, loaded from the queue head
  assign ev_rd_o = ev_nempty_i && (!vld_q || pop);
  assign is_pix  = ev_i.status == ST_PIXEL;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= 1'b0;
    else if (ev_rd_o) vld_q <= 1'b1;
    else if (pop) vld_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (ev_rd_o) begin
      st_q   <= ev_i.status;
      px_q   <= is_pix ? ox_q + 16'(ev_i.col) : 16'd0;
      py_q   <= is_pix ? oy_q + 16'(ev_i.yoff) : 16'd0;
      col_q  <= ev_i.color;
      last_q <= ev_i.last;
    end
  end

  assign empty        = !vld_q;
  assign status_o     = st_q;
  assign pixel_x_o    = px_q;
  assign pixel_y_o    = py_q;
  assign color_o      = col_q;
  assign last_pixel_o = last_q;

`ifndef SYNTHESIS
  a_load_needs_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_rd_o |-> ev_nempty_i) else $error("load from empty queue");
  a_hold_when_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q && !pop) |=> vld_q) else $error("result dropped");
  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_rd_o |-> (!vld_q || pop)) else $error("result overwritten");
`endif
endmodule
`default_nettype wire

[design/bmp24_stream_to_rgb565_core.sv]
// Top level: BMP byte stream in, RGB565 pixels with screen positions out.
// Throughput: one byte per cycle, sustained; full rises only when the
//   two-entry queue between parser and output register backs up.
// Result path: the edge that accepts a request's last byte writes it into the
//   queue; the output register loads it from the queue head when free or popped.
// Reset (rst_ni, asynchronous, low) idles the parser, empties the queue and
//   clears origin_x and origin_y to zero.
`default_nettype none
module bmp24_stream_to_rgb565_core (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [2:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  wire         push,
  output logic        full,
  input  wire  [7:0]  data_byte_i,
  input  wire         start_of_file_i,
  output logic        empty,
  input  wire         pop,
  output logic [1:0]  status_o,
  output logic [15:0] pixel_x_o,
  output logic [15:0] pixel_y_o,
  output logic [15:0] color_o,
  output logic        last_pixel_o
);
  import bsr_pkg::*;

  logic acc, ev_valid, q_nempty, q_rd;
  ev_t  ev, q_head;

  assign pready = 1'b1;
  assign acc    = push && !full;

  bsr_front u_front (
    .clk_i, .rst_ni, .acc_i(acc), .data_byte_i, .start_of_file_i,
    .ev_valid_o(ev_valid), .ev_o(ev)
  );

  bsr_fifo u_fifo (
    .clk_i, .rst_ni, .wr_i(ev_valid), .wdata_i(ev), .full_o(full),
    .rd_i(q_rd), .rdata_o(q_head), .nempty_o(q_nempty)
  );

  bsr_back u_back (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata,
    .ev_nempty_i(q_nempty), .ev_i(q_head), .ev_rd_o(q_rd), .empty, .pop,
    .status_o, .pixel_x_o, .pixel_y_o, .color_o, .last_pixel_o
  );
endmodule
`default_nettype wire

[tb/bmp24_stream_to_rgb565_core_tb.sv]
// Testbench for the BMP byte stream to RGB565 pixel converter.
`timescale 1ns / 1ps
module bmp24_stream_to_rgb565_core_tb;
  import bsr_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  data_byte_i = '0;
  logic        start_of_file_i = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [1:0]  status_o;
  logic [15:0] pixel_x_o, pixel_y_o, color_o;
  logic        last_pixel_o;

  localparam logic [2:0] AddrOriginX = 3'd0;
  localparam logic [2:0] AddrOriginY = 3'd4;

  typedef enum logic [2:0] {
    PH_IDLE, PH_HEADER, PH_SKIP, PH_PIXEL, PH_PAD
  } phase_e;

  typedef struct {
    status_e     st;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] color;
    logic        last;
  } pixel_req_t;

  bmp24_stream_to_rgb565_core dut (.*);

  always #10 clk_i = ~clk_i;

  // Predicts pixel requests from accepted bytes and checks them in order.
  class pix_scoreboard;
    logic [15:0] org_x, org_y;
    phase_e      phase;
    logic [31:0] pos, offset, width, height, comp, col, row;
    logic [15:0] bpp;
    logic [1:0]  tri_idx, pad_left;
    logic [7:0]  blue, green;
    pixel_req_t  pending[$];
    int          errors;

    function new();
      org_x = '0; org_y = '0; errors = 0;
      restart();
      phase = PH_IDLE;
    endfunction

    function void restart();
      phase = PH_HEADER; pos = '0; offset = '0; width = '0; height = '0;
      comp = '0; bpp = '0; col = '0; row = '0; tri_idx = '0; pad_left = '0;
      blue = '0; green = '0;
    endfunction

    function bit nonpos(logic [31:0] v);
      return v == 0 || v[31];
    endfunction

    function void add(status_e st, logic [15:0] x, logic [15:0] y,
                      logic [15:0] c, logic l);
      pixel_req_t r;
      r.st = st; r.x = x; r.y = y; r.color = c; r.last = l;
      pending.push_back(r);
    endfunction

    // Advance the parser by one accepted byte.
    function void note_byte(logic [7:0] d, logic sof);
      logic [31:0] p;
      bit row_end, fin;
      if (sof) restart();
      case (phase)
        PH_HEADER: begin
          p = pos;
          if ((p == 0 && d != SigB) || (p == 1 && d != SigM)) begin
            phase = PH_IDLE;
            add(ST_BAD_SIG, 0, 0, 0, 0);
            return;
          end
          if (p >= 10 && p <= 13) offset |= 32'(d) << (8 * (p - 10));
          else if (p >= 18 && p <= 21) width |= 32'(d) << (8 * (p - 18));
          else if (p >= 22 && p <= 25) height |= 32'(d) << (8 * (p - 22));
          else if (p >= 28 && p <= 29) bpp |= 16'(d) << (8 * (p - 28));
          else if (p >= 30 && p <= 33) comp |= 32'(d) << (8 * (p - 30));
          pos = p + 1;
          if (p != 33) return;
          if (bpp != 24 || comp != 0 || offset < 34 ||
              (!nonpos(width) && width > 4096) ||
              (!nonpos(height) && height > 4096)) begin
            phase = PH_IDLE;
            add(ST_UNSUP, 0, 0, 0, 0);
          end else if (nonpos(width) || nonpos(height)) phase = PH_IDLE;
          else if (offset == pos) phase = PH_PIXEL;
          else phase = PH_SKIP;
        end
        PH_SKIP: begin
          pos = pos + 1;
          if (pos == offset) phase = PH_PIXEL;
        end
        PH_PIXEL: begin
          if (tri_idx == 0) begin
            blue = d; tri_idx = 1;
          end else if (tri_idx == 1) begin
            green = d; tri_idx = 2;
          end else begin
            row_end = (col + 1 == width);
            fin = row_end && (row + 1 == height);
            add(ST_PIXEL, org_x + col[15:0], org_y + 16'(height - 1 - row),
                {d[7:3], green[7:2], blue[7:3]}, fin);
            tri_idx = 0;
            if (fin) phase = PH_IDLE;
            else if (row_end) begin
              col = 0; row = row + 1; pad_left = width[1:0];
              if (pad_left != 0) phase = PH_PAD;
            end else col = col + 1;
          end
        end
        PH_PAD: begin
          pad_left = pad_left - 1;
          if (pad_left == 0) phase = PH_PIXEL;
        end
        default: ;
      endcase
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %0h expected %0h", what, got, want);
      errors++;
    endtask

    task check_result(logic [1:0] st, logic [15:0] x, logic [15:0] y,
                      logic [15:0] c, logic l);
      pixel_req_t w;
      if (pending.size() == 0) begin
        report("unexpected request", st, 0);
        return;
      end
      w = pending.pop_front();
      if (st != w.st) report("status", st, w.st);
      if (x != w.x) report("pixel_x", x, w.x);
      if (y != w.y) report("pixel_y", y, w.y);
      if (c != w.color) report("color", c, w.color);
      if (l != w.last) report("last_pixel", l, w.last);
    endtask
  endclass

  pix_scoreboard sb = new();
  int  push_gap_mode = 0, pop_gap_mode = 0;
  int  idle_cycles = 0;
  int  pop_hold = 0;
  logic [7:0] file_q[$];

  function int gap_len(int mode);
    if (mode == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0;
  endfunction

  // Result side: random pop stalls, check every accepted request.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty)
        sb.check_result(status_o, pixel_x_o, pixel_y_o, color_o, last_pixel_o);
      if (pop_hold > 0) pop_hold = pop_hold - 1;
      else pop_hold = gap_len(pop_gap_mode);
      pop <= (pop_hold == 0);
    end
  end

  // Watchdog on cycles with no accepted request on either side.
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 3000) begin
      $display("bmp24_stream_to_rgb565_core_tb: FAIL");
      $finish;
    end
  end

  task reg_write(logic [2:0] addr, logic [15:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr;
    pwdata <= {{16{val[15]}}, val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == AddrOriginX) sb.org_x = val;
    else sb.org_y = val;
    @(posedge clk_i);
  endtask

  task send_byte(logic [7:0] b, logic sof);
    int g;
    data_byte_i <= b; start_of_file_i <= sof; push <= 1'b1;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    sb.note_byte(b, sof);
    g = gap_len(push_gap_mode);
    if (g > 0) begin
      push <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task send_file();
    foreach (file_q[i]) send_byte(file_q[i], i == 0);
  endtask

  task put32(int at, logic [31:0] v);
    for (int k = 0; k < 4; k++) file_q[at + k] = v[8*k +: 8];
  endtask

  // Build a file: header fields, filler up to the offset, rows with padding.
  task build_file(logic [7:0] sig0, logic [7:0] sig1, logic [31:0] off,
                  logic [31:0] w, logic [31:0] h, logic [15:0] bits,
                  logic [31:0] comp, int pix_rows, int trailing);
    int rowbytes;
    file_q.delete();
    for (int i = 0; i < 34; i++) file_q.push_back(8'($urandom));
    file_q[0] = sig0; file_q[1] = sig1;
    put32(10, off); put32(18, w); put32(22, h); put32(30, comp);
    file_q[28] = bits[7:0]; file_q[29] = bits[15:8];
    while (file_q.size() < off && file_q.size() < 64)
      file_q.push_back(8'($urandom));
    rowbytes = (w[31] || w > 4096) ? 0 : (w * 3 + 3) & ~3;
    for (int r = 0; r < pix_rows; r++)
      for (int i = 0; i < rowbytes; i++) file_q.push_back(8'($urandom));
    repeat (trailing) file_q.push_back(8'($urandom));
  endtask

  task good_file(int w, int h, int off);
    build_file(SigB, SigM, off, w, h, Bpp24, 0, h, $urandom_range(0, 2));
  endtask

  task drain();
    if (push) push <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task random_file();
    int kind, w, h;
    kind = $urandom_range(0, 19);
    w = $urandom_range(1, 6);
    h = $urandom_range(1, 4);
    if (kind < 14) good_file(w, h, $urandom_range(0, 1) ? 34 : $urandom_range(35, 60));
    else if (kind == 14) build_file(8'($urandom), SigM, 54, w, h, Bpp24, 0, h, 0);
    else if (kind == 15) build_file(SigB, 8'($urandom), 54, w, h, Bpp24, 0, h, 0);
    else if (kind == 16)
      build_file(SigB, SigM, 54, w, h, 16'($urandom_range(0, 32)), 0, h, 0);
    else if (kind == 17) build_file(SigB, SigM, 54, w, h, Bpp24, $urandom, h, 0);
    else if (kind == 18) begin
      // truncated file, cut short by the next start
      good_file(w, h, 54);
      repeat ($urandom_range(1, file_q.size() - 1)) void'(file_q.pop_back());
    end else begin
      // stray bytes with no start while idle
      repeat ($urandom_range(1, 8)) send_byte(8'($urandom), 1'b0);
      good_file(w, h, 34);
    end
    send_file();
  endtask

  initial begin
    int sent;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at reset origin, then extreme origins.
    repeat (3) send_byte(8'hFF, 1'b0);
    good_file(1, 1, 34); send_file();
    good_file(3, 2, 40); send_file();
    build_file(8'h00, SigM, 34, 2, 2, Bpp24, 0, 0, 2); send_file();
    build_file(SigB, 8'hFF, 34, 2, 2, Bpp24, 0, 0, 2); send_file();
    build_file(SigB, SigM, 34, 2, 2, 16'd32, 0, 0, 0); send_file();
    build_file(SigB, SigM, 34, 2, 2, 16'hFF18, 0, 0, 0); send_file();
    build_file(SigB, SigM, 34, 2, 2, Bpp24, 32'hFFFF_FFFF, 0, 0); send_file();
    build_file(SigB, SigM, 33, 2, 2, Bpp24, 0, 0, 0); send_file();
    build_file(SigB, SigM, 32'hFFFF_FFFF, 2, 2, Bpp24, 0, 0, 4); send_file();
    build_file(SigB, SigM, 34, 4097, 1, Bpp24, 0, 0, 0); send_file();
    build_file(SigB, SigM, 34, 1, 4097, Bpp24, 0, 0, 0); send_file();
    build_file(SigB, SigM, 34, 0, 2, Bpp24, 0, 0, 3); send_file();
    build_file(SigB, SigM, 34, 2, 32'h8000_0000, Bpp24, 0, 0, 3); send_file();
    build_file(SigB, SigM, 34, 32'hFFFF_FFFE, 32'h7FFF_FFFF, Bpp24, 0, 0, 0);
    send_file();
    // largest sizes, cut short after a few pixels
    good_file(4096, 1, 34);
    repeat (file_q.size() - 49) void'(file_q.pop_back());
    send_file();
    good_file(1, 4096, 34);
    repeat (file_q.size() - 49) void'(file_q.pop_back());
    send_file();
    drain();
    reg_write(AddrOriginX, 16'h7FFF);
    reg_write(AddrOriginY, 16'h7FFF);
    good_file(5, 3, 40); send_file();
    drain();
    reg_write(AddrOriginX, 16'h8000);
    reg_write(AddrOriginY, 16'h8000);
    good_file(2, 3, 34); send_file();
    drain();

    // Random part in phases of random origin and idling.
    sent = 0;
    for (int ph = 0; ph < 3; ph++) begin
      push_gap_mode = ph;
      pop_gap_mode = ph % 2;
      reg_write(AddrOriginX, 16'($urandom));
      reg_write(AddrOriginY, 16'($urandom));
      random_file();
      sent += file_q.size();
      while (sent < (ph + 1) * 70) begin
        random_file();
        sent += file_q.size();
      end
      drain();
    end

    drain();
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("bmp24_stream_to_rgb565_core_tb: PASS");
    else
      $display("bmp24_stream_to_rgb565_core_tb: FAIL");
    $finish;
  end
endmodule
